[rtl/core/htw_pkg.sv]
// shared types, codes and default sizes of the hashed timing wheel
package htw_pkg;

    localparam int SLOT_COUNT_DEF   = 1024;
    localparam int MAX_TIMERS_DEF   = 64;
    localparam int TIMEOUT_BITS_DEF = 24;

    localparam int KIND_W    = 2;
    localparam int ID_W      = 6;
    localparam int TIMEOUT_W = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_ADJUST = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic shift;
        logic write;
        logic clear;
    } t_cell_ctl;

endpackage

[rtl/core/htw_cell.sv]
// one timer entry of the circulating entry ring
module htw_cell import htw_pkg::*; #(
    parameter int SW = 10,
    parameter int QW = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic          i_sh_valid,
    input  logic [SW-1:0] i_sh_slot,
    input  logic [QW-1:0] i_sh_rot,
    input  logic [QW-1:0] i_sh_rq,
    input  logic [SW-1:0] i_sh_rr,
    input  logic          i_sh_per,
    input  logic [SW-1:0] i_wr_slot,
    input  logic [QW-1:0] i_wr_rot,
    input  logic [SW-1:0] i_wr_rr,
    input  logic          i_wr_per,
    output logic          o_valid,
    output logic [SW-1:0] o_slot,
    output logic [QW-1:0] o_rot,
    output logic [QW-1:0] o_rq,
    output logic [SW-1:0] o_rr,
    output logic          o_per
);

    logic          r_valid;
    logic [SW-1:0] r_slot;
    logic [QW-1:0] r_rot;
    logic [QW-1:0] r_rq;
    logic [SW-1:0] r_rr;
    logic          r_per;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_sh_valid;
        end else if (i_ctl.write) begin
            r_valid <= 1'b1;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_slot <= i_sh_slot;
            r_rot  <= i_sh_rot;
            r_rq   <= i_sh_rq;
            r_rr   <= i_sh_rr;
            r_per  <= i_sh_per;
        end else if (i_ctl.write) begin
            r_slot <= i_wr_slot;
            r_rot  <= i_wr_rot;
            r_rq   <= i_wr_rot;
            r_rr   <= i_wr_rr;
            r_per  <= i_wr_per;
        end
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;
    assign o_rot   = r_rot;
    assign o_rq    = r_rq;
    assign o_rr    = r_rr;
    assign o_per   = r_per;

endmodule

[rtl/core/htw_div.sv]
// constant divider of a tick count by the slot count, reciprocal multiply then remainder
module htw_div import htw_pkg::*; #(
    parameter int TW         = 24,
    parameter int SLOT_COUNT = 1024,
    parameter int SW         = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [TW-1:0] i_dividend,
    output logic          o_done,
    output logic [TW-1:0] o_quo,
    output logic [SW-1:0] o_rem
);

    localparam int SH = TW + SW;
    localparam int MW = TW + 2;
    localparam int PW = TW + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);

    logic          r_v1;
    logic          r_v2;
    logic          r_done;
    logic [TW-1:0] r_n;
    logic [TW-1:0] r_quo;
    logic [SW-1:0] r_rem;
    logic [PW-1:0] prod;
    logic [SW-1:0] back;

    // quotient from the rounded-up reciprocal, exact over the whole dividend range
    assign prod = {{MW{1'b0}}, r_n} * {{TW{1'b0}}, MW'(RECIP)};
    // remainder only needs the low bits of quotient times slot count
    assign back = r_quo[SW-1:0] * SW'(SLOT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_dividend;
        end
        if (r_v1) begin
            r_quo <= TW'(prod[PW-1:SH]);
        end
        if (r_v2) begin
            r_rem <= r_n[SW-1:0] - back;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

[rtl/core/hashed_timing_wheel.sv]
// Hashed timing wheel over a ring of MAX_TIMERS timer cells and SLOT_COUNT slots. An add or
// adjust holds the input while a pipelined constant divider splits the tick count into
// rotation and slot offset; a remove leaves the input free. A tick circulates the whole
// ring once through the head cell, one timer per cycle while the result side does not stall.
// Expiries come out in ascending timer index; the last one of a tick carries o_last.
module hashed_timing_wheel import htw_pkg::*; #(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int MAX_TIMERS   = MAX_TIMERS_DEF,
    parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [ID_W-1:0]      i_timer_id,
    input  logic [TIMEOUT_W-1:0] i_timeout,
    input  logic                 i_periodic,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ID_W-1:0]      o_expired_id,
    output logic                 o_expired_periodic,
    output logic                 o_last
);

    localparam int TW  = (TIMEOUT_BITS < TIMEOUT_W) ? TIMEOUT_BITS : TIMEOUT_W;
    localparam int SW  = $clog2(SLOT_COUNT);
    localparam int QW  = TW - SW + 1;
    localparam int STW = $clog2(MAX_TIMERS + 1);

    t_state          r_state, n_state;
    logic [SW-1:0]   r_cur;
    logic [STW-1:0]  r_step;
    logic [ID_W-1:0] r_id;
    logic            r_per;

    logic            r_pv;
    logic [ID_W-1:0] r_p_id;
    logic            r_p_per;
    logic            r_ov;
    logic [ID_W-1:0] r_o_id;
    logic            r_o_per;
    logic            r_o_last;

    logic            c_valid [MAX_TIMERS];
    logic [SW-1:0]   c_slot  [MAX_TIMERS];
    logic [QW-1:0]   c_rot   [MAX_TIMERS];
    logic [QW-1:0]   c_rq    [MAX_TIMERS];
    logic [SW-1:0]   c_rr    [MAX_TIMERS];
    logic            c_per   [MAX_TIMERS];

    logic            h_valid;
    logic [SW-1:0]   h_slot;
    logic [QW-1:0]   h_rot;
    logic            h_per;
    logic [SW:0]     h_sum;

    logic            acc;
    logic            id_ok;
    logic [TW-1:0]   ticks;
    logic            div_start;
    logic            div_done;
    logic [TW-1:0]   div_quo;
    logic [SW-1:0]   div_rem;
    logic [SW:0]     wr_sum;
    logic [SW-1:0]   wr_slot;

    logic            wr_en;
    logic            clr_en;
    logic            shift;
    logic            expire;
    logic            out_free;
    logic            scan_end;

    assign o_in_stall = (r_state != ST_IDLE);
    assign acc   = i_in_valid && !o_in_stall;
    assign id_ok = 32'(i_timer_id) < MAX_TIMERS;
    assign ticks = (i_timeout[TW-1:0] == '0) ? TW'(1) : i_timeout[TW-1:0];

    assign out_free = !r_ov || !i_out_stall;

    // head of the ring, processed and fed back to the tail
    assign h_sum = {1'b0, r_cur} + {1'b0, c_rr[0]};
    always_comb begin
        h_valid = c_valid[0];
        h_slot  = c_slot[0];
        h_rot   = c_rot[0];
        h_per   = c_per[0];
        expire  = 1'b0;
        if (c_valid[0] && c_slot[0] == r_cur) begin
            if (c_rot[0] != '0) begin
                h_rot = c_rot[0] - 1'b1;
            end else begin
                expire = 1'b1;
                if (!c_per[0]) begin
                    h_valid = 1'b0;
                end else begin
                    h_slot = (h_sum >= (SW + 1)'(SLOT_COUNT)) ?
                        SW'(h_sum - (SW + 1)'(SLOT_COUNT)) : h_sum[SW-1:0];
                    h_rot  = (c_rr[0] == '0 && c_rq[0] != '0) ? c_rq[0] - 1'b1 : c_rq[0];
                end
            end
        end
    end

    assign wr_sum  = {1'b0, r_cur} + {1'b0, div_rem};
    assign wr_slot = (wr_sum >= (SW + 1)'(SLOT_COUNT)) ?
        SW'(wr_sum - (SW + 1)'(SLOT_COUNT)) : wr_sum[SW-1:0];

    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        wr_en      = 1'b0;
        clr_en     = 1'b0;
        shift      = 1'b0;
        scan_end   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_kind == KIND_TICK) begin
                        n_state = ST_SCAN;
                    end else if (id_ok) begin
                        if (i_kind == KIND_REMOVE) begin
                            clr_en = 1'b1;
                        end else begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    wr_en   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                shift = !(expire && r_pv && !out_free);
                if (shift && r_step == STW'(MAX_TIMERS - 1)) begin
                    scan_end = 1'b1;
                    n_state  = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pv || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cur   <= '0;
            r_step  <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_step <= '0;
            end else if (shift) begin
                r_step <= r_step + 1'b1;
            end
            if (scan_end) begin
                r_cur <= (r_cur == SW'(SLOT_COUNT - 1)) ? '0 : r_cur + 1'b1;
            end
            if (shift && expire && r_pv) begin
                r_ov <= 1'b1;
            end else if (r_state == ST_FLUSH && r_pv && out_free) begin
                r_ov <= 1'b1;
                r_pv <= 1'b0;
            end else if (out_free) begin
                r_ov <= 1'b0;
            end
            if (shift && expire) begin
                r_pv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_id  <= i_timer_id;
            r_per <= i_periodic;
        end
        if (shift && expire) begin
            r_p_id  <= ID_W'(r_step);
            r_p_per <= c_per[0];
            if (r_pv) begin
                r_o_id   <= r_p_id;
                r_o_per  <= r_p_per;
                r_o_last <= 1'b0;
            end
        end else if (r_state == ST_FLUSH && r_pv && out_free) begin
            r_o_id   <= r_p_id;
            r_o_per  <= r_p_per;
            r_o_last <= 1'b1;
        end
    end

    htw_div #(
        .TW         (TW),
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ticks),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
        t_cell_ctl     ctl;
        logic          sh_valid;
        logic [SW-1:0] sh_slot;
        logic [QW-1:0] sh_rot;
        logic [QW-1:0] sh_rq;
        logic [SW-1:0] sh_rr;
        logic          sh_per;

        assign ctl.shift = shift;
        assign ctl.write = wr_en && (r_id == ID_W'(g));
        assign ctl.clear = clr_en && (i_timer_id == ID_W'(g));

        if (g == MAX_TIMERS - 1) begin : g_tail
            assign sh_valid = h_valid;
            assign sh_slot  = h_slot;
            assign sh_rot   = h_rot;
            assign sh_rq    = c_rq[0];
            assign sh_rr    = c_rr[0];
            assign sh_per   = h_per;
        end else begin : g_link
            assign sh_valid = c_valid[g+1];
            assign sh_slot  = c_slot[g+1];
            assign sh_rot   = c_rot[g+1];
            assign sh_rq    = c_rq[g+1];
            assign sh_rr    = c_rr[g+1];
            assign sh_per   = c_per[g+1];
        end

        htw_cell #(
            .SW (SW),
            .QW (QW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_sh_valid (sh_valid),
            .i_sh_slot  (sh_slot),
            .i_sh_rot   (sh_rot),
            .i_sh_rq    (sh_rq),
            .i_sh_rr    (sh_rr),
            .i_sh_per   (sh_per),
            .i_wr_slot  (wr_slot),
            .i_wr_rot   (div_quo[QW-1:0]),
            .i_wr_rr    (div_rem),
            .i_wr_per   (r_per),
            .o_valid    (c_valid[g]),
            .o_slot     (c_slot[g]),
            .o_rot      (c_rot[g]),
            .o_rq       (c_rq[g]),
            .o_rr       (c_rr[g]),
            .o_per      (c_per[g])
        );
    end

    assign o_out_valid        = r_ov;
    assign o_expired_id       = r_o_id;
    assign o_expired_periodic = r_o_per;
    assign o_last             = r_o_last;

endmodule

[tb/sv/tb_hashed_timing_wheel.sv]
// self-checking testbench of the hashed timing wheel: predicted expiries against the block
module tb_hashed_timing_wheel;
    import htw_pkg::*;

    localparam int SLOT_W      = $clog2(SLOT_COUNT_DEF);
    localparam int ROT_W       = TIMEOUT_W - SLOT_W;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 200;
    localparam int PRINT_MAX   = 40;

    typedef struct {
        t_kind                kind;
        logic [ID_W-1:0]      id;
        logic [TIMEOUT_W-1:0] timeout;
        logic                 periodic;
    } t_txn;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            periodic;
        logic            last;
    } t_expiry;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    t_kind                drv_kind     = KIND_TICK;
    logic [ID_W-1:0]      drv_id       = '0;
    logic [TIMEOUT_W-1:0] drv_timeout  = '0;
    logic                 drv_periodic = 1'b0;
    logic                 out_stall    = 1'b0;

    logic                 dut_in_stall;
    logic                 dut_out_valid;
    logic [ID_W-1:0]      dut_id;
    logic                 dut_periodic;
    logic                 dut_last;

    t_txn    txn_q[$];
    t_expiry expiry_q[$];

    // predicted wheel state
    logic [SLOT_W-1:0]    cur_slot = '0;
    logic                 tmr_valid  [MAX_TIMERS_DEF] = '{default: 1'b0};
    logic [SLOT_W-1:0]    tmr_slot   [MAX_TIMERS_DEF];
    logic [ROT_W-1:0]     tmr_rot    [MAX_TIMERS_DEF];
    logic [TIMEOUT_W-1:0] tmr_reload [MAX_TIMERS_DEF];
    logic                 tmr_per    [MAX_TIMERS_DEF];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int errors      = 0;
    int n_txns      = 0;
    int n_ticks     = 0;
    int n_checked   = 0;
    int n_wraps     = 0;
    int cycle_cnt   = 0;

    hashed_timing_wheel u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (dut_in_stall),
        .i_kind             (drv_kind),
        .i_timer_id         (drv_id),
        .i_timeout          (drv_timeout),
        .i_periodic         (drv_periodic),
        .o_out_valid        (dut_out_valid),
        .i_out_stall        (out_stall),
        .o_expired_id       (dut_id),
        .o_expired_periodic (dut_periodic),
        .o_last             (dut_last)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic arm_timer(input int idx, input logic [TIMEOUT_W-1:0] ticks);
        int n;
        n = (ticks == '0) ? 1 : int'(ticks);
        tmr_rot[idx]   = ROT_W'(n / SLOT_COUNT_DEF);
        tmr_slot[idx]  = SLOT_W'((int'(cur_slot) + n) % SLOT_COUNT_DEF);
        tmr_valid[idx] = 1'b1;
    endtask

    task automatic push_txn(input t_kind k, input int id, input logic [TIMEOUT_W-1:0] to,
                            input logic per);
        t_txn t;
        t.kind     = k;
        t.id       = ID_W'(id);
        t.timeout  = to;
        t.periodic = per;
        txn_q.push_back(t);
    endtask

    function automatic logic [TIMEOUT_W-1:0] pick_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return TIMEOUT_W'($urandom_range(0, 24));
        else if (r < 70)
            return TIMEOUT_W'($urandom_range(25, 200));
        else if (r < 80)
            return TIMEOUT_W'($urandom_range(1000, 1100));
        else if (r < 85)
            return ($urandom_range(0, 1) != 0) ? 24'd1024 : 24'd2048;
        else if (r < 88)
            return '1;
        return TIMEOUT_W'($urandom());
    endfunction

    function automatic t_txn rand_txn(input int tick_pct, input int id_hi);
        t_txn t;
        int   r;
        r = $urandom_range(0, 99);
        if (r < tick_pct)
            t.kind = KIND_TICK;
        else if (r < tick_pct + (100 - tick_pct) * 55 / 100)
            t.kind = KIND_ADD;
        else if (r < tick_pct + (100 - tick_pct) * 75 / 100)
            t.kind = KIND_REMOVE;
        else
            t.kind = KIND_ADJUST;
        if ($urandom_range(0, 99) < 30)
            t.id = ID_W'($urandom_range(0, (id_hi < 7) ? id_hi : 7));
        else
            t.id = ID_W'($urandom_range(0, id_hi));
        t.timeout  = pick_timeout();
        t.periodic = 1'($urandom_range(0, 1));
        return t;
    endfunction

    task automatic wait_drained();
        while (txn_q.size() != 0 || in_valid || expiry_q.size() != 0)
            @(negedge clk);
    endtask

    // sender
    always @(posedge clk) begin : txn_driver
        t_txn nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !dut_in_stall) begin
            if (txn_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                nxt = txn_q.pop_front();
                in_valid     <= 1'b1;
                drv_kind     <= nxt.kind;
                drv_id       <= nxt.id;
                drv_timeout  <= nxt.timeout;
                drv_periodic <= nxt.periodic;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge clk) begin : expiry_stall
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // expected expiries of every accepted transaction
    always @(posedge clk) begin : wheel_predict
        int      hits;
        t_expiry held;
        t_expiry e;
        if (rst_n && in_valid && !dut_in_stall) begin
            n_txns++;
            if (drv_kind == KIND_TICK) begin
                n_ticks++;
                hits = 0;
                for (int t = 0; t < MAX_TIMERS_DEF; t++) begin
                    if (tmr_valid[t] && tmr_slot[t] == cur_slot) begin
                        if (tmr_rot[t] != '0) begin
                            tmr_rot[t] = tmr_rot[t] - 1'b1;
                        end else begin
                            if (hits != 0)
                                expiry_q.push_back(held);
                            e.id       = ID_W'(t);
                            e.periodic = tmr_per[t];
                            e.last     = 1'b0;
                            held       = e;
                            hits++;
                            if (!tmr_per[t]) begin
                                tmr_valid[t] = 1'b0;
                            end else begin
                                arm_timer(t, tmr_reload[t]);
                                if (tmr_slot[t] == cur_slot && tmr_rot[t] != '0)
                                    tmr_rot[t] = tmr_rot[t] - 1'b1;
                            end
                        end
                    end
                end
                if (hits != 0) begin
                    held.last = 1'b1;
                    expiry_q.push_back(held);
                end
                cur_slot = cur_slot + 1'b1;
                if (cur_slot == '0)
                    n_wraps++;
            end else if (drv_kind == KIND_REMOVE) begin
                tmr_valid[drv_id] = 1'b0;
            end else begin
                tmr_reload[drv_id] = drv_timeout;
                tmr_per[drv_id]    = drv_periodic;
                arm_timer(int'(drv_id), drv_timeout);
            end
        end
    end

    always @(posedge clk) begin : expiry_check
        t_expiry e;
        if (rst_n && dut_out_valid && !out_stall) begin
            if (expiry_q.size() == 0) begin
                if (errors < PRINT_MAX)
                    $display("%0t: unexpected expiry: expected none, got id %0d per %0b last %0b",
                             $time, dut_id, dut_periodic, dut_last);
                errors++;
            end else begin
                e = expiry_q.pop_front();
                n_checked++;
                if (dut_id !== e.id || dut_periodic !== e.periodic || dut_last !== e.last) begin
                    if (errors < PRINT_MAX)
                        $display("%0t: exp id %0d per %0b last %0b, got id %0d per %0b last %0b",
                                 $time, e.id, e.periodic, e.last, dut_id, dut_periodic,
                                 dut_last);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_hashed_timing_wheel: done, errors");
        $finish;
    end

    initial begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 37;
        rx_idle_pct = 74;
        // zero and full timeouts, both ends of the index range, re-arm and no-op cases
        push_txn(KIND_ADD, 0, 24'd0, 1'b0);
        push_txn(KIND_ADD, 63, '1, 1'b1);
        push_txn(KIND_ADD, 1, 24'd1, 1'b1);
        push_txn(KIND_ADJUST, 2, 24'd3, 1'b0);
        push_txn(KIND_ADD, 3, 24'd2, 1'b0);
        push_txn(KIND_ADD, 3, 24'd4, 1'b1);
        push_txn(KIND_REMOVE, 4, TIMEOUT_W'($urandom()), 1'b1);
        push_txn(KIND_ADD, 5, 24'd1024, 1'b1);
        push_txn(KIND_ADD, 6, 24'd1025, 1'b0);
        repeat (6) push_txn(KIND_TICK, $urandom_range(0, 63), TIMEOUT_W'($urandom()),
                            1'($urandom_range(0, 1)));
        push_txn(KIND_REMOVE, 1, '0, 1'b0);
        push_txn(KIND_ADJUST, 63, 24'd2, 1'b0);
        push_txn(KIND_ADD, 7, 24'd16, 1'b1);
        repeat (4) push_txn(KIND_TICK, $urandom_range(0, 63), TIMEOUT_W'($urandom()),
                            1'($urandom_range(0, 1)));
        push_txn(KIND_REMOVE, 63, '1, 1'b1);
        repeat (110) txn_q.push_back(rand_txn(45, 63));
        wait_drained();

        tx_idle_pct = 74;
        rx_idle_pct = 37;
        repeat (110) txn_q.push_back(rand_txn(45, 63));
        wait_drained();

        // long receiver hold-off with the sender pushing tick-heavy traffic
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (20) push_txn(KIND_ADD, $urandom_range(8, 39),
                             TIMEOUT_W'($urandom_range(1, 6)), 1'b1);
        repeat (60) txn_q.push_back(rand_txn(70, 63));
        hold_req = hold_req + 1;
        wait_drained();

        // long timers next to a run of ticks so their rotations count down
        push_txn(KIND_ADD, 40, 24'd1024, 1'b1);
        push_txn(KIND_ADD, 41, 24'd1025, 1'b0);
        push_txn(KIND_ADD, 42, 24'd1030, 1'b1);
        push_txn(KIND_ADD, 43, 24'd1500, 1'b1);
        repeat (60) txn_q.push_back(rand_txn(97, 31));
        wait_drained();

        repeat (20) txn_q.push_back(rand_txn(45, 63));
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expiry_q.size() != 0) begin
            $display("%0t: %0d expected expiries never arrived", $time, expiry_q.size());
            errors++;
        end
        $display("ran %0d transactions including %0d ticks, checked %0d expiries",
                 n_txns, n_ticks, n_checked);
        $display("wheel wrapped %0d times, %0d errors", n_wraps, errors);
        if (errors == 0) begin
            $display("tb_hashed_timing_wheel: done, clean");
        end else begin
            $display("tb_hashed_timing_wheel: done, errors");
        end
        $finish;
    end

endmodule
